### hw/rtl/assert_macros.svh
// assertion macros used by the checker file
// expects a clock named clk and an active-low reset named arst_n in scope
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked at every rising edge outside reset
`define WPAL_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// implication that must hold in the cycle after its trigger
`define WPAL_ASSERT_NEXT(label, trig, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (trig) |=> (cons)) \
		else $error(msg);

`endif

### hw/rtl/wpal_pkg.sv
// shared constants and level codes for the windowed peak activity level block
// no dependencies
package wpal_pkg;

	// widths of the transaction fields and registers
	localparam int DATA_W   = 64;
	localparam int THR_W    = 10;
	localparam int LEVEL_W  = 2;
	localparam int CFG_IDX_W = 1;
	localparam int PROD_W   = DATA_W + THR_W;

	// default window length
	localparam int WINDOW_DEPTH_DEF = 32;

	// ratio scale: one in thousandths
	localparam logic [THR_W-1:0] PERMILLE_ONE = THR_W'(1000);

	// register reset values
	localparam logic [THR_W-1:0] HIGH_THR_RST = THR_W'(400);
	localparam logic [THR_W-1:0] LOW_THR_RST  = THR_W'(100);

	// register indexes
	localparam logic [CFG_IDX_W-1:0] REG_HIGH_THR = CFG_IDX_W'(0);
	localparam logic [CFG_IDX_W-1:0] REG_LOW_THR  = CFG_IDX_W'(1);

	// activity level codes
	localparam logic [LEVEL_W-1:0] LEVEL_QUIET = LEVEL_W'(0);
	localparam logic [LEVEL_W-1:0] LEVEL_MILD  = LEVEL_W'(1);
	localparam logic [LEVEL_W-1:0] LEVEL_SOME  = LEVEL_W'(2);
	localparam logic [LEVEL_W-1:0] LEVEL_HEAVY = LEVEL_W'(3);

endpackage

### hw/rtl/wpal_cell.sv
// one slot of the delta window with its stage of the running peak
// depends on wpal_pkg
module wpal_cell (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        shift_en,
	input  logic [wpal_pkg::DATA_W-1:0] delta_in,
	input  logic [wpal_pkg::DATA_W-1:0] max_in,
	output logic [wpal_pkg::DATA_W-1:0] delta_out,
	output logic [wpal_pkg::DATA_W-1:0] max_out
);

	logic [wpal_pkg::DATA_W-1:0] delta_q;
	logic [wpal_pkg::DATA_W-1:0] max_q;

	// window slot, cleared at reset, shifts one place per recorded reading
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			delta_q <= '0;
		end else if (shift_en) begin
			delta_q <= delta_in;
		end
	end

	// running peak handed on to the next cell every cycle
	always_ff @(posedge clk) begin
		max_q <= (delta_q > max_in) ? delta_q : max_in;
	end

	assign delta_out = delta_q;
	assign max_out   = max_q;

endmodule

### hw/rtl/windowed_peak_activity_level.sv
// top level of the windowed peak activity level block
// depends on wpal_pkg and wpal_cell
//
// Input channel: in_valid / in_stall with total_events, one counter reading
// per transaction. Output channel: out_valid / out_stall with activity_level,
// event_delta and window_peak, exactly one result per reading.
// The delta to the previous reading enters a chain of WINDOW_DEPTH cells; the
// running peak ripples one cell per cycle through the scan state. The products
// are then registered in the multiply state, and the emit state grades the
// level as the result enters the output register. A new reading is taken
// once the previous one has left for the output register. A reading with
// previous total zero (first after reset) skips the scan, gives a quiet
// result and records nothing. A stalled result holds in the output register;
// the next reading is still accepted and worked on, then waits until the
// register frees. Reset clears the window and the previous total and loads
// the default thresholds (heavy above 400 permille, some above 100 permille
// of the peak). Configuration is written through cfg_wr_en / cfg_index /
// cfg_data; the user must write it only while idle, which the block itself
// does not enforce.
module windowed_peak_activity_level #(
	parameter int WINDOW_DEPTH = wpal_pkg::WINDOW_DEPTH_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	// configuration
	input  logic                           cfg_wr_en,
	input  logic [wpal_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [wpal_pkg::THR_W-1:0]     cfg_data,
	// input channel
	input  logic                           in_valid,
	output logic                           in_stall,
	input  logic [wpal_pkg::DATA_W-1:0]    total_events,
	// output channel
	output logic                           out_valid,
	input  logic                           out_stall,
	output logic [wpal_pkg::LEVEL_W-1:0]   activity_level,
	output logic [wpal_pkg::DATA_W-1:0]    event_delta,
	output logic [wpal_pkg::DATA_W-1:0]    window_peak
);

	localparam int CNT_W = (WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 1;
	localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(WINDOW_DEPTH - 1);

	// sequencer codes
	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_SCAN = 2'd1;
	localparam logic [1:0] ST_MULT = 2'd2;
	localparam logic [1:0] ST_EMIT = 2'd3;

	logic [1:0]                         state_q;
	logic [CNT_W-1:0]                   cnt_q;
	logic [wpal_pkg::THR_W-1:0]         high_thr_q;
	logic [wpal_pkg::THR_W-1:0]         low_thr_q;
	logic [wpal_pkg::DATA_W-1:0]        prev_total_q;
	logic [wpal_pkg::DATA_W-1:0]        delta_q;
	logic [wpal_pkg::DATA_W-1:0]        peak_q;
	logic [wpal_pkg::PROD_W-1:0]        prod_delta_s1;
	logic [wpal_pkg::PROD_W-1:0]        prod_high_s1;
	logic [wpal_pkg::PROD_W-1:0]        prod_low_s1;
	logic                               out_valid_q;
	logic [wpal_pkg::LEVEL_W-1:0]       level_q;
	logic [wpal_pkg::DATA_W-1:0]        out_delta_q;
	logic [wpal_pkg::DATA_W-1:0]        out_peak_q;

	logic                               in_accept;
	logic                               record;
	logic                               out_free;
	logic [wpal_pkg::DATA_W-1:0]        new_delta;
	logic [wpal_pkg::DATA_W-1:0]        chain_tail;
	logic [wpal_pkg::LEVEL_W-1:0]       level_d;
	logic [wpal_pkg::DATA_W-1:0]        delta_chain [WINDOW_DEPTH+1];
	logic [wpal_pkg::DATA_W-1:0]        max_chain   [WINDOW_DEPTH+1];

	assign in_stall  = (state_q != ST_IDLE);
	assign in_accept = in_valid && !in_stall;
	assign record    = in_accept && (prev_total_q != '0);
	assign new_delta = total_events - prev_total_q;
	assign out_free  = !out_valid_q || !out_stall;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			high_thr_q <= wpal_pkg::HIGH_THR_RST;
			low_thr_q  <= wpal_pkg::LOW_THR_RST;
		end else if (cfg_wr_en) begin
			unique case (cfg_index)
				wpal_pkg::REG_HIGH_THR: high_thr_q <= cfg_data;
				wpal_pkg::REG_LOW_THR:  low_thr_q  <= cfg_data;
				default: ;
			endcase
		end
	end

	// window chain: newest delta enters cell zero, running peak starts at zero
	assign delta_chain[0] = new_delta;
	assign max_chain[0]   = '0;

	for (genvar i = 0; i < WINDOW_DEPTH; i++) begin : g_cell
		wpal_cell u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.shift_en  (record),
			.delta_in  (delta_chain[i]),
			.max_in    (max_chain[i]),
			.delta_out (delta_chain[i+1]),
			.max_out   (max_chain[i+1])
		);
	end

	assign chain_tail = max_chain[WINDOW_DEPTH];

	// sequencer: scan the chain, form products, hand over to the output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			cnt_q        <= '0;
			prev_total_q <= '0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (in_accept) begin
						prev_total_q <= total_events;
						cnt_q        <= '0;
						state_q      <= record ? ST_SCAN : ST_EMIT;
					end
				end
				ST_SCAN: begin
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == CNT_LAST) begin
						state_q <= ST_MULT;
					end
				end
				ST_MULT: begin
					state_q <= ST_EMIT;
				end
				ST_EMIT: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// delta and peak of the transaction in flight
	always_ff @(posedge clk) begin
		if (in_accept) begin
			delta_q <= record ? new_delta : '0;
			peak_q  <= '0;
		end else if (state_q == ST_MULT) begin
			peak_q <= chain_tail;
		end
	end

	// products for the ratio compare, delta*1000 against threshold*peak
	always_ff @(posedge clk) begin
		if (state_q == ST_MULT) begin
			prod_delta_s1 <= wpal_pkg::PROD_W'(delta_q) *
				wpal_pkg::PROD_W'(wpal_pkg::PERMILLE_ONE);
			prod_high_s1  <= wpal_pkg::PROD_W'(chain_tail) * wpal_pkg::PROD_W'(high_thr_q);
			prod_low_s1   <= wpal_pkg::PROD_W'(chain_tail) * wpal_pkg::PROD_W'(low_thr_q);
		end
	end

	// level grading, heavy tested before some
	always_comb begin
		if (peak_q == '0) begin
			level_d = wpal_pkg::LEVEL_QUIET;
		end else if (prod_delta_s1 > prod_high_s1) begin
			level_d = wpal_pkg::LEVEL_HEAVY;
		end else if (prod_delta_s1 > prod_low_s1) begin
			level_d = wpal_pkg::LEVEL_SOME;
		end else if (delta_q != '0) begin
			level_d = wpal_pkg::LEVEL_MILD;
		end else begin
			level_d = wpal_pkg::LEVEL_QUIET;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (state_q == ST_EMIT && out_free) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_EMIT && out_free) begin
			level_q     <= level_d;
			out_delta_q <= delta_q;
			out_peak_q  <= peak_q;
		end
	end

	assign out_valid      = out_valid_q;
	assign activity_level = level_q;
	assign event_delta    = out_delta_q;
	assign window_peak    = out_peak_q;

endmodule

### hw/rtl/wpal_checker.sv
// port-level checks for the windowed peak activity level block, bound to the top
// depends on wpal_pkg and assert_macros.svh
`include "assert_macros.svh"

module wpal_checker (
	input logic                           clk,
	input logic                           arst_n,
	input logic                           in_valid,
	input logic                           in_stall,
	input logic                           out_valid,
	input logic                           out_stall,
	input logic [wpal_pkg::LEVEL_W-1:0]   activity_level,
	input logic [wpal_pkg::DATA_W-1:0]    event_delta,
	input logic [wpal_pkg::DATA_W-1:0]    window_peak
);

	// a stalled result keeps its level and peak
	`WPAL_ASSERT_NEXT(a_stall_hold, out_valid && out_stall,
		out_valid && $stable(activity_level) && $stable(window_peak), "stalled result changed")

	// one reading at a time: input closes right after a transaction
	`WPAL_ASSERT_NEXT(a_one_in_flight, in_valid && !in_stall, in_stall, "second reading taken early")

	// the newest delta is part of the window, so it never exceeds the peak
	`WPAL_ASSERT(a_delta_le_peak, out_valid |-> (event_delta <= window_peak),
		"delta above window peak")

	// any level above quiet needs a nonzero delta and peak
	`WPAL_ASSERT(a_level_nonzero, (out_valid && activity_level != wpal_pkg::LEVEL_QUIET) |->
		(event_delta != '0 && window_peak != '0), "active level with zero delta")

endmodule

bind windowed_peak_activity_level wpal_checker u_wpal_checker (.*);
